// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the swing coefficient RTL.
// Both macros expect signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SQC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define SQC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sqc_pkg.sv =====
`timescale 1ns / 1ps
package sqc_pkg;

  localparam int WORD_BITS = 32;
  localparam int HW        = WORD_BITS - 1;
  localparam int SW        = WORD_BITS + 1;
  localparam int M2W       = WORD_BITS + 4;
  localparam int PW        = 2 * SW;
  localparam int KW        = PW + 2;
  localparam int KLW       = KW / 2;
  localparam int LOW       = M2W + KLW + 1;
  localparam int HIW       = M2W + KW - KLW;
  localparam int NW        = M2W + KW + 2;
  localparam int DMW       = 2 * WORD_BITS;
  localparam int QW        = WORD_BITS + 1;
  localparam int RW        = DMW + QW;

  localparam int NAX  = 3;
  localparam int NDIV = 2 * NAX;
  localparam int NPP  = 7;
  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  localparam int INW  = 2 * NAX * WORD_BITS;
  localparam int OUTW = 3 * NAX * WORD_BITS;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int BACK_STAGES = 6;

  localparam logic [HW-1:0] SWING_RESET = HW'(6554);
  localparam logic [QW:0]   LIM_POS = (QW+1)'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic [QW:0]   LIM_NEG = (QW+1)'(64'd1 << (WORD_BITS - 1));

  // One footstep after classification in the front part.
  typedef struct packed {
    logic [NAX-1:0][WORD_BITS-1:0] p0;
    logic [NAX-1:0][SW-1:0]        d;
    logic [M2W-1:0]                m2;
    logic [SW-1:0]                 s;
    logic [WORD_BITS-1:0]          zi;
    logic [WORD_BITS-1:0]          zf;
    logic                          sing;
  } sqc_item_t;

  // Data that rides along the back pipeline untouched.
  typedef struct packed {
    logic [NAX-1:0][WORD_BITS-1:0] p0;
    logic                          sing;
    logic [DMW-1:0]                dm;
    logic                          dneg;
  } sqc_side_t;

  // Numerator magnitudes handed to the divider.
  typedef struct packed {
    logic [NDIV-1:0][NW-1:0] nmag;
    logic [NDIV-1:0]         neg;
    logic [DMW-1:0]          dm;
    logic [NAX-1:0][WORD_BITS-1:0] p0;
    logic                    sing;
  } sqc_num_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [NDIV-1:0][RW-1:0] rem;
    logic [NDIV-1:0][QW-1:0] q;
    logic [NDIV-1:0]         neg;
    logic [NDIV-1:0]         big;
    logic [DMW-1:0]          dm;
    logic [NAX-1:0][WORD_BITS-1:0] p0;
    logic                    sing;
  } sqc_div_t;

endpackage

// ===== hdl/sqc_front.sv =====
`timescale 1ns / 1ps
module sqc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sqc_pkg::INW-1:0]       in_tdata,
  input  logic                          cfg_wr_en,
  input  logic [sqc_pkg::HW-1:0]        cfg_wr_data,
  output logic                          fq_valid,
  input  logic                          fq_ready,
  output sqc_pkg::sqc_item_t            fq_item
);

  logic [sqc_pkg::HW-1:0]               swing_h_r;
  logic                                 fv_r;
  sqc_pkg::sqc_item_t                   item_r;
  sqc_pkg::sqc_item_t                   item_nxt;
  logic signed [sqc_pkg::WORD_BITS-1:0] zi;
  logic signed [sqc_pkg::WORD_BITS-1:0] zf;
  logic signed [sqc_pkg::WORD_BITS-1:0] lo;
  logic signed [sqc_pkg::SW-1:0]        s_sum;
  logic signed [sqc_pkg::M2W-1:0]       lift;

  assign in_tready = !fv_r || fq_ready;
  assign fq_valid  = fv_r;
  assign fq_item   = item_r;

  always_comb begin
    for (int a = 0; a < sqc_pkg::NAX; a++) begin
      item_nxt.p0[a] = in_tdata[a*sqc_pkg::WORD_BITS +: sqc_pkg::WORD_BITS];
      item_nxt.d[a]  =
        sqc_pkg::SW'($signed(in_tdata[(a+sqc_pkg::NAX)*sqc_pkg::WORD_BITS +:
                                      sqc_pkg::WORD_BITS])) -
        sqc_pkg::SW'($signed(in_tdata[a*sqc_pkg::WORD_BITS +: sqc_pkg::WORD_BITS]));
    end
    zi    = $signed(in_tdata[sqc_pkg::AX_Z*sqc_pkg::WORD_BITS +: sqc_pkg::WORD_BITS]);
    zf    = $signed(in_tdata[(sqc_pkg::AX_Z+sqc_pkg::NAX)*sqc_pkg::WORD_BITS +:
                             sqc_pkg::WORD_BITS]);
    lo    = (zi < zf) ? zi : zf;
    s_sum = sqc_pkg::SW'(zi) + sqc_pkg::SW'(zf);
    // Twice the midpoint lift above the start height.
    lift  = sqc_pkg::M2W'(lo) + sqc_pkg::M2W'($signed({1'b0, swing_h_r})) -
            sqc_pkg::M2W'(zi);
    item_nxt.m2   = lift <<< 1;
    item_nxt.s    = s_sum;
    item_nxt.zi   = zi;
    item_nxt.zf   = zf;
    item_nxt.sing = (s_sum == '0) || (zi == '0) || (zf == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r      <= 1'b0;
      swing_h_r <= sqc_pkg::SWING_RESET;
    end else begin
      if (cfg_wr_en) begin
        swing_h_r <= cfg_wr_data;
      end
      if (in_tready) begin
        fv_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== hdl/sqc_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sqc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sqc_pkg::sqc_item_t in_item,
  output logic               out_valid,
  input  logic               pop,
  output sqc_pkg::sqc_item_t out_item
);

  sqc_pkg::sqc_item_t           mem [sqc_pkg::QDEPTH];
  logic [sqc_pkg::QAW-1:0]      wr_ptr_r;
  logic [sqc_pkg::QAW-1:0]      rd_ptr_r;
  logic [sqc_pkg::QCW-1:0]      cnt_r;
  logic                         push;

  assign in_ready  = cnt_r != sqc_pkg::QCW'(sqc_pkg::QDEPTH);
  assign out_valid = cnt_r != '0;
  assign push      = in_valid && in_ready;
  assign out_item  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `SQC_ASSERT(a_cnt_bound, cnt_r <= sqc_pkg::QCW'(sqc_pkg::QDEPTH), "queue overfilled")
  `SQC_ASSERT_NEXT(a_cnt_drain, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "bad drain count")

endmodule

// ===== hdl/sqc_back.sv =====
`timescale 1ns / 1ps
module sqc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               qv,
  input  sqc_pkg::sqc_item_t q_item,
  output logic               pop,
  output logic               bv,
  output sqc_pkg::sqc_num_t  num
);

  logic [sqc_pkg::BACK_STAGES-1:0] v_r;

  // Stage 1: squares and cross products of the heights.
  logic signed [sqc_pkg::PW-1:0]  s_e, zi_e, zf_e;
  logic signed [sqc_pkg::PW-1:0]  s2_r, z2_r, zs_r, den_r;
  sqc_pkg::sqc_item_t             it1_r;

  // Stage 2: multiplier operands.
  logic signed [sqc_pkg::KW-1:0]  k1, k2;
  logic signed [sqc_pkg::PW-1:0]  dabs;
  logic signed [sqc_pkg::M2W-1:0] pa_nxt [sqc_pkg::NPP];
  logic signed [sqc_pkg::KW-1:0]  pk_nxt [sqc_pkg::NPP];
  logic signed [sqc_pkg::M2W-1:0] pa_r   [sqc_pkg::NPP];
  logic signed [sqc_pkg::KW-1:0]  pk_r   [sqc_pkg::NPP];
  sqc_pkg::sqc_side_t             side_nxt;
  sqc_pkg::sqc_side_t             side2_r, side3_r, side4_r, side5_r;

  // Stage 3: partial products on the low and high halves.
  logic signed [sqc_pkg::LOW-1:0] lo_nxt [sqc_pkg::NPP];
  logic signed [sqc_pkg::HIW-1:0] hi_nxt [sqc_pkg::NPP];
  logic signed [sqc_pkg::LOW-1:0] lo_r   [sqc_pkg::NPP];
  logic signed [sqc_pkg::HIW-1:0] hi_r   [sqc_pkg::NPP];

  // Stages 4 to 6: full products, numerators, magnitudes.
  logic signed [sqc_pkg::NW-1:0]  pp_r   [sqc_pkg::NPP];
  logic signed [sqc_pkg::NW-1:0]  n_nxt  [sqc_pkg::NDIV];
  logic signed [sqc_pkg::NW-1:0]  n_r    [sqc_pkg::NDIV];
  sqc_pkg::sqc_num_t              num_nxt;
  sqc_pkg::sqc_num_t              num_r;

  assign pop = en && qv;
  assign bv  = v_r[sqc_pkg::BACK_STAGES-1];
  assign num = num_r;

  always_comb begin
    s_e  = $signed(q_item.s);
    zi_e = $signed(q_item.zi);
    zf_e = $signed(q_item.zf);
  end

  always_comb begin
    k1 = sqc_pkg::KW'(s2_r) - sqc_pkg::KW'(z2_r);
    k2 = sqc_pkg::KW'(zs_r) - sqc_pkg::KW'(s2_r);
    // The x and y numerators factor into one product each.
    pa_nxt[0] = sqc_pkg::M2W'($signed(it1_r.d[sqc_pkg::AX_X]));
    pa_nxt[1] = sqc_pkg::M2W'($signed(it1_r.d[sqc_pkg::AX_X]));
    pa_nxt[2] = sqc_pkg::M2W'($signed(it1_r.d[sqc_pkg::AX_Y]));
    pa_nxt[3] = sqc_pkg::M2W'($signed(it1_r.d[sqc_pkg::AX_Y]));
    pa_nxt[4] = $signed(it1_r.m2);
    pa_nxt[5] = sqc_pkg::M2W'($signed(it1_r.d[sqc_pkg::AX_Z]));
    pa_nxt[6] = sqc_pkg::M2W'($signed(it1_r.d[sqc_pkg::AX_Z]));
    pk_nxt[0] = k1;
    pk_nxt[1] = k2;
    pk_nxt[2] = k1;
    pk_nxt[3] = k2;
    pk_nxt[4] = sqc_pkg::KW'(s2_r);
    pk_nxt[5] = sqc_pkg::KW'(z2_r);
    pk_nxt[6] = sqc_pkg::KW'(zs_r);
    dabs           = den_r[sqc_pkg::PW-1] ? -den_r : den_r;
    side_nxt.p0    = it1_r.p0;
    side_nxt.sing  = it1_r.sing;
    side_nxt.dm    = dabs[sqc_pkg::DMW-1:0];
    side_nxt.dneg  = den_r[sqc_pkg::PW-1];
  end

  always_comb begin
    for (int j = 0; j < sqc_pkg::NPP; j++) begin
      lo_nxt[j] = sqc_pkg::LOW'(pa_r[j]) *
                  $signed({{(sqc_pkg::LOW-sqc_pkg::KLW){1'b0}},
                           pk_r[j][sqc_pkg::KLW-1:0]});
      hi_nxt[j] = sqc_pkg::HIW'(pa_r[j]) *
                  sqc_pkg::HIW'($signed(pk_r[j][sqc_pkg::KW-1:sqc_pkg::KLW]));
    end
  end

  always_comb begin
    n_nxt[0] = pp_r[0];
    n_nxt[1] = pp_r[2];
    n_nxt[2] = pp_r[4] - pp_r[5];
    n_nxt[3] = pp_r[1];
    n_nxt[4] = pp_r[3];
    n_nxt[5] = pp_r[6] - pp_r[4];
  end

  always_comb begin
    for (int i = 0; i < sqc_pkg::NDIV; i++) begin
      num_nxt.nmag[i] = n_r[i][sqc_pkg::NW-1] ? -n_r[i] : n_r[i];
      num_nxt.neg[i]  = n_r[i][sqc_pkg::NW-1] ^ side5_r.dneg;
    end
    num_nxt.dm   = side5_r.dm;
    num_nxt.p0   = side5_r.p0;
    num_nxt.sing = side5_r.sing;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[sqc_pkg::BACK_STAGES-2:0], qv};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r    <= s_e * s_e;
      z2_r    <= (zf_e * zf_e) <<< 1;
      zs_r    <= (zf_e * s_e) <<< 1;
      den_r   <= (zf_e * zi_e) <<< 1;
      it1_r   <= q_item;
      side2_r <= side_nxt;
      side3_r <= side2_r;
      side4_r <= side3_r;
      side5_r <= side4_r;
      for (int j = 0; j < sqc_pkg::NPP; j++) begin
        pa_r[j] <= pa_nxt[j];
        pk_r[j] <= pk_nxt[j];
        lo_r[j] <= lo_nxt[j];
        hi_r[j] <= hi_nxt[j];
        pp_r[j] <= (sqc_pkg::NW'(hi_r[j]) <<< sqc_pkg::KLW) + sqc_pkg::NW'(lo_r[j]);
      end
      for (int i = 0; i < sqc_pkg::NDIV; i++) begin
        n_r[i] <= n_nxt[i];
      end
      num_r <= num_nxt;
    end
  end

endmodule

// ===== hdl/sqc_div.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sqc_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     bv,
  input  sqc_pkg::sqc_num_t        num,
  output logic                     en,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [sqc_pkg::OUTW-1:0] out_tdata,
  output logic                     out_tuser
);

  logic [sqc_pkg::QW:0]          v_r;
  sqc_pkg::sqc_div_t             st_nxt [sqc_pkg::QW+1];
  sqc_pkg::sqc_div_t             st_r   [sqc_pkg::QW+1];
  logic [sqc_pkg::RW:0]          trial;
  sqc_pkg::sqc_div_t             fin;
  logic                          up;
  logic [sqc_pkg::QW:0]          qr;
  logic [sqc_pkg::QW:0]          lim;
  logic [sqc_pkg::QW:0]          qv;
  logic [sqc_pkg::QW:0]          res;
  logic                          out_valid_r;
  logic [sqc_pkg::OUTW-1:0]      out_data_r;
  logic [sqc_pkg::OUTW-1:0]      out_data_nxt;
  logic                          out_user_r;

  assign en         = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Entry stage flags quotients that cannot fit; the rest are exact below 2^QW.
  // After it, one quotient bit per stage, most significant first.
  always_comb begin
    for (int i = 0; i < sqc_pkg::NDIV; i++) begin
      st_nxt[0].rem[i] = num.nmag[i][sqc_pkg::RW-1:0];
      st_nxt[0].q[i]   = '0;
      st_nxt[0].big[i] = num.nmag[i] >= (sqc_pkg::NW'(num.dm) << sqc_pkg::QW);
    end
    st_nxt[0].neg  = num.neg;
    st_nxt[0].dm   = num.dm;
    st_nxt[0].p0   = num.p0;
    st_nxt[0].sing = num.sing;
    trial = '0;
    for (int j = 1; j <= sqc_pkg::QW; j++) begin
      st_nxt[j] = st_r[j-1];
      for (int i = 0; i < sqc_pkg::NDIV; i++) begin
        trial = {1'b0, st_r[j-1].rem[i]} -
                ((sqc_pkg::RW+1)'(st_r[j-1].dm) << (sqc_pkg::QW - j));
        if (!trial[sqc_pkg::RW]) begin
          st_nxt[j].rem[i]                = trial[sqc_pkg::RW-1:0];
          st_nxt[j].q[i][sqc_pkg::QW - j] = 1'b1;
        end
      end
    end
  end

  // Round half away from zero, clamp, apply the sign.
  always_comb begin
    fin          = st_r[sqc_pkg::QW];
    out_data_nxt = '0;
    up = 1'b0; qr = '0; lim = '0; qv = '0; res = '0;
    if (!fin.sing) begin
      for (int a = 0; a < sqc_pkg::NAX; a++) begin
        out_data_nxt[a*sqc_pkg::WORD_BITS +: sqc_pkg::WORD_BITS] = fin.p0[a];
      end
      for (int i = 0; i < sqc_pkg::NDIV; i++) begin
        up  = {fin.rem[i][sqc_pkg::DMW-1:0], 1'b0} >= {1'b0, fin.dm};
        qr  = {1'b0, fin.q[i]} + (sqc_pkg::QW+1)'(up);
        lim = fin.neg[i] ? sqc_pkg::LIM_NEG : sqc_pkg::LIM_POS;
        qv  = (fin.big[i] || (qr > lim)) ? lim : qr;
        res = fin.neg[i] ? -qv : qv;
        out_data_nxt[(sqc_pkg::NAX+i)*sqc_pkg::WORD_BITS +: sqc_pkg::WORD_BITS] =
          res[sqc_pkg::WORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[sqc_pkg::QW-1:0], bv};
      out_valid_r <= v_r[sqc_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j <= sqc_pkg::QW; j++) begin
        st_r[j] <= st_nxt[j];
      end
      out_data_r <= out_data_nxt;
      out_user_r <= fin.sing;
    end
  end

  `SQC_ASSERT(a_sing_zero, out_valid_r && out_user_r |-> out_data_r == '0, "singular not zeroed")

endmodule

// ===== hdl/swing_quadratic_coefficients_top.sv =====
// Swing curve coefficients: for each footstep, given start and end points in
// signed Q16.16, the block returns c0, c1 and c2 per axis so that
// pos(u) = c0 + c1*u + c2*u^2 passes through the start, the end, and a raised
// midpoint at u = zf/(zi+zf). Input transfers carry six 32-bit fields on
// in_tdata; each output transfer carries nine coefficients on out_tdata and
// the singular flag on out_tuser. When the solve is undefined the flag is set
// and all coefficients are zero. The swing height register is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce. Reset loads 6554 (0.1 m).
// Throughput is one footstep per cycle while out_tready stays high. A footstep
// passes the front register, the queue, six product stages, an entry stage
// and 33 divider stages of one quotient bit each, and the output register.
// A front register classifies each footstep and feeds a two-entry queue, so
// the input side keeps taking transfers while the back pipeline is stalled.
// When out_tready is low while a result waits, the whole back pipeline holds;
// once the queue and the front register fill, in_tready drops. Reset clears
// all valid flags and the queue but leaves other data registers as they were.
`timescale 1ns / 1ps
module swing_quadratic_coefficients_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z (lowest bits first)
  input  logic [sqc_pkg::INW-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // coef0_x, coef0_y, coef0_z, coef1_x, coef1_y, coef1_z,
  // coef2_x, coef2_y, coef2_z (lowest bits first)
  output logic [sqc_pkg::OUTW-1:0] out_tdata,
  // singular
  output logic                     out_tuser,
  input  logic                     cfg_wr_en,
  input  logic [sqc_pkg::HW-1:0]   cfg_wr_data
);

  logic               fq_valid;
  logic               fq_ready;
  sqc_pkg::sqc_item_t fq_item;
  logic               qb_valid;
  logic               qb_pop;
  sqc_pkg::sqc_item_t qb_item;
  logic               bd_valid;
  sqc_pkg::sqc_num_t  bd_num;
  logic               stage_en;

  // Front: unpacks the transfer, forms differences and the midpoint lift,
  // and flags the singular cases.
  sqc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fq_valid    (fq_valid),
    .fq_ready    (fq_ready),
    .fq_item     (fq_item)
  );

  // Queue decouples the front from the stallable back pipeline.
  sqc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .pop       (qb_pop),
    .out_item  (qb_item)
  );

  // Back: products and the six numerators of the closed-form solve.
  sqc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (stage_en),
    .qv     (qb_valid),
    .q_item (qb_item),
    .pop    (qb_pop),
    .bv     (bd_valid),
    .num    (bd_num)
  );

  // Divider, rounding, saturation and the output register.
  sqc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .bv         (bd_valid),
    .num        (bd_num),
    .en         (stage_en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== verif/sqc_checker.sv =====
`timescale 1ns / 1ps
module sqc_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [sqc_pkg::INW-1:0]  in_tdata,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [sqc_pkg::OUTW-1:0] out_tdata,
  input  logic                     out_tuser,
  input  logic                     cfg_wr_en,
  input  logic [sqc_pkg::HW-1:0]   cfg_wr_data,
  output int                       fail_count,
  output int                       pending,
  output int                       coef_count,
  output int                       singular_count,
  output int                       sat_count
);
  import sqc_pkg::*;

  typedef struct {
    logic [OUTW-1:0] coefs;
    logic            singular;
  } coef_set_t;

  logic [HW-1:0] lift;
  coef_set_t     expected_q[$];

  // Rounded, saturated quotient; numerators fit easily in 200 bits.
  function automatic logic [WORD_BITS-1:0] div_near_sat(logic signed [199:0] num,
                                                        logic signed [199:0] den);
    logic signed [199:0] q, r, an, ad;
    logic                neg;
    neg = (num < 0) != (den < 0);
    an  = num < 0 ? -num : num;
    ad  = den < 0 ? -den : den;
    q   = an / ad;
    r   = an % ad;
    if (2 * r >= ad) q = q + 1;
    if (!neg && q > 200'sd2147483647) q = 200'sd2147483647;
    if (neg && q > 200'sd2147483648) q = 200'sd2147483648;
    if (neg) q = -q;
    return q[WORD_BITS-1:0];
  endfunction

  function automatic coef_set_t solve_curve(logic [INW-1:0] pts, logic [HW-1:0] h);
    coef_set_t           c;
    logic signed [199:0] p0 [3];
    logic signed [199:0] p1 [3];
    logic signed [199:0] zi, zf, s, den, d, m2, lo, n1, n2;
    logic [WORD_BITS-1:0] c1, c2;
    for (int a = 0; a < 3; a++) begin
      p0[a] = $signed(pts[a*WORD_BITS +: WORD_BITS]);
      p1[a] = $signed(pts[(a+3)*WORD_BITS +: WORD_BITS]);
    end
    zi = p0[2];
    zf = p1[2];
    s  = zi + zf;
    c.coefs = '0;
    c.singular = 1'b1;
    if (s == 0 || zi == 0 || zf == 0) return c;
    c.singular = 1'b0;
    den = 2 * zf * zi;
    lo  = zi < zf ? zi : zf;
    for (int a = 0; a < 3; a++) begin
      d  = p1[a] - p0[a];
      m2 = (a < 2) ? d : 2 * (lo + $signed({169'd0, h}) - zi);
      n1 = m2 * s * s - 2 * d * zf * zf;
      n2 = 2 * d * zf * s - m2 * s * s;
      c1 = div_near_sat(n1, den);
      c2 = div_near_sat(n2, den);
      c.coefs[a*WORD_BITS +: WORD_BITS]     = p0[a][WORD_BITS-1:0];
      c.coefs[(a+3)*WORD_BITS +: WORD_BITS] = c1;
      c.coefs[(a+6)*WORD_BITS +: WORD_BITS] = c2;
    end
    return c;
  endfunction

  // Counts are gathered per edge and each counter is updated once.
  always @(posedge clk) begin
    coef_set_t e;
    int        nfail;
    int        nsat;
    nfail = 0;
    nsat  = 0;
    if (!rst_n) begin
      lift <= SWING_RESET;
      fail_count <= 0;
      coef_count <= 0;
      singular_count <= 0;
      sat_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_wr_en) lift <= cfg_wr_data;
      if (in_tvalid && in_tready) begin
        e = solve_curve(in_tdata, lift);
        expected_q.push_back(e);
        if (e.singular) singular_count <= singular_count + 1;
        for (int k = 3; k < 9; k++)
          if (e.coefs[k*WORD_BITS +: WORD_BITS] == 32'h7fffffff ||
              e.coefs[k*WORD_BITS +: WORD_BITS] == 32'h80000000)
            nsat = nsat + 1;
      end
      if (out_tvalid && out_tready) begin
        coef_count <= coef_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h / %b", $time,
                   out_tdata, out_tuser);
          nfail = nfail + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.singular !== out_tuser) begin
            $display("%0t: singular expected %b actual %b", $time, e.singular,
                     out_tuser);
            nfail = nfail + 1;
          end
          for (int k = 0; k < 9; k++)
            if (e.coefs[k*WORD_BITS +: WORD_BITS] !== out_tdata[k*WORD_BITS +: WORD_BITS])
            begin
              $display("%0t: coefficient %0d expected %h actual %h", $time, k,
                       e.coefs[k*WORD_BITS +: WORD_BITS],
                       out_tdata[k*WORD_BITS +: WORD_BITS]);
              nfail = nfail + 1;
            end
        end
      end
      sat_count  <= sat_count + nsat;
      fail_count <= fail_count + nfail;
      pending    <= expected_q.size();
    end
  end
endmodule

// ===== verif/swing_quadratic_coefficients_top_tb.sv =====
`timescale 1ns / 1ps
module swing_quadratic_coefficients_top_tb;
  import sqc_pkg::*;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [INW-1:0]  in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUTW-1:0] out_tdata;
  logic            out_tuser;
  logic            cfg_wr_en = 1'b0;
  logic [HW-1:0]   cfg_wr_data = '0;

  int  fail_count, pending, coef_count, singular_count, sat_count;
  int  cycle_count = 0;
  // Set while the sender may idle, and while the receiver may stall.
  bit  send_gaps = 1'b1;
  bit  recv_gaps = 1'b1;
  bit  hold_off = 1'b0;
  int  sent = 0;

  localparam int LIMIT = 400000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  swing_quadratic_coefficients_top i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_wr_en, .cfg_wr_data
  );

  sqc_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_wr_en, .cfg_wr_data, .fail_count, .pending,
    .coef_count, .singular_count, .sat_count
  );

  // The timeout guards against a stuck handshake anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("swing_quadratic_coefficients_top test failed");
      $finish;
    end
  end

  // The receiver stalls in random bursts, stays ready in quiet stretches, and
  // holds off entirely while hold_off is set so the queue fills up.
  initial begin
    int run;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end else if (recv_gaps && $urandom_range(3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        run = $urandom_range(20, 1);
        repeat (run) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(7))
      0: return 32'h8000_0000 | $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom_range(8) - 4;
      3, 4: return $urandom;
      default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // Random z values lean toward realistic feet, but also hit zeros,
  // opposite values and the word extremes.
  function automatic logic [INW-1:0] make_step();
    logic [INW-1:0] p;
    for (int k = 0; k < 6; k++) p[k*32 +: 32] = pick_coord();
    case ($urandom_range(9))
      0: p[5*32 +: 32] = -p[2*32 +: 32];
      1: p[2*32 +: 32] = '0;
      2: p[5*32 +: 32] = '0;
      3, 4, 5: begin
        p[2*32 +: 32] = $urandom_range(32'h0002_0000, 1);
        p[5*32 +: 32] = $urandom_range(32'h0002_0000, 1);
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_step(logic [INW-1:0] p);
    if (send_gaps && $urandom_range(4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk iff in_tready);
    sent++;
  endtask

  // Waits out the pipeline so a register write never meets an item in flight.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_lift(logic [HW-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [INW-1:0] p;
    logic [HW-1:0]  lifts [5];
    lifts = '{'0, 31'h7fff_ffff, 31'd1, 31'd6554, 31'd32768};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed footsteps at the reset lift: extremes, zero z on either end,
    // z values that cancel, and equal ends.
    for (int k = 0; k < 20; k++) begin
      p = '0;
      case (k)
        0: p = {6{32'h7fff_ffff}};
        1: p = {6{32'h8000_0000}};
        2: p = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        3: p = {32'h0001_0000, 32'd5, 32'd5, 32'h0000_0000, 32'd1, 32'd1};
        4: p = {32'h0000_0000, 32'd5, 32'd5, 32'h0001_0000, 32'd1, 32'd1};
        5: p = {32'hffff_0000, 32'd7, 32'd7, 32'h0001_0000, 32'd1, 32'd1};
        6: p = {32'd1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h8000_0000};
        7: p = {32'h0000_8000, 32'h0001_0000, 32'h0002_0000,
                32'h0000_8000, 32'h0000_0000, 32'h0000_0000};
        8: p = {32'hffff_ffff, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0};
        9: p = {32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0};
        default: p = make_step();
      endcase
      send_step(p);
    end
    drain();

    // Phases through several lift settings, including both extremes.
    foreach (lifts[j]) begin
      write_lift(lifts[j]);
      for (int k = 0; k < 300; k++) begin
        if (j == 2 && k == 100) hold_off = 1'b1;
        send_step(make_step());
      end
      drain();
    end

    // Final stretch with no idling on either side.
    write_lift(HW'($urandom));
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    for (int k = 0; k < 380; k++) send_step(make_step());
    drain();

    $display("Sent %0d footsteps over seven lift phases, %0d results checked.",
             sent, coef_count);
    $display("%0d singular cases and %0d saturated coefficients expected.",
             singular_count, sat_count);
    if (fail_count == 0)
      $display("swing_quadratic_coefficients_top test passed");
    else
      $display("swing_quadratic_coefficients_top test failed");
    $finish;
  end

  // The long hold-off is counted here, apart from the stimulus.
  initial begin
    @(posedge clk iff hold_off);
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/sqc_pkg.sv
hdl/sqc_front.sv
hdl/sqc_queue.sv
hdl/sqc_back.sv
hdl/sqc_div.sv
hdl/swing_quadratic_coefficients_top.sv
verif/sqc_checker.sv
verif/swing_quadratic_coefficients_top_tb.sv
